// ===== sv/png_scanline_unfilter_unit_assert.svh =====
// Assertion macros used by the checker of the scanline unfilter unit.
`ifndef PNG_SCANLINE_UNFILTER_UNIT_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PNGSU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PNGSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/pngsu_pkg.sv =====
// Package with the constants, register indexes, filter codes and Paeth predictor of the unfilter unit.
`timescale 1ns / 1ps
`default_nettype none
package pngsu_pkg;

	localparam int MAX_ROW_BYTES       = 4096;
	localparam int MAX_BYTES_PER_PIXEL = 8;
	localparam int ROW_W               = 13;
	localparam int BPP_W               = 4;
	localparam int ADDR_W              = $clog2(MAX_ROW_BYTES);
	localparam int HIST_IDX_W          = $clog2(MAX_BYTES_PER_PIXEL) > 0 ?
		$clog2(MAX_BYTES_PER_PIXEL) : 1;
	localparam int CFG_IDX_W           = 1;
	localparam int CFG_DATA_W          = 13;

	localparam logic [BPP_W-1:0] BPP_RESET = BPP_W'(3);
	localparam logic [ROW_W-1:0] ROW_RESET = ROW_W'(384);

	localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES       = CFG_IDX_W'(1);

	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filter_t;

	localparam logic [7:0] FILT_MAX_CODE = 8'd4;

	// Paeth predictor with ties resolved toward a, then b.
	function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		logic signed [10:0] pa_s;
		logic signed [10:0] pb_s;
		logic signed [10:0] pc_s;
		logic [10:0] pa;
		logic [10:0] pb;
		logic [10:0] pc;
		pa_s = $signed({3'b000, b}) - $signed({3'b000, c});
		pb_s = $signed({3'b000, a}) - $signed({3'b000, c});
		pc_s = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
		pa = pa_s[10] ? 11'(-pa_s) : 11'(pa_s);
		pb = pb_s[10] ? 11'(-pb_s) : 11'(pb_s);
		pc = pc_s[10] ? 11'(-pc_s) : 11'(pc_s);
		if (pa <= pb && pa <= pc) begin
			paeth_pred = a;
		end else if (pb <= pc) begin
			paeth_pred = b;
		end else begin
			paeth_pred = c;
		end
	endfunction

endpackage
`default_nettype wire

// ===== sv/png_scanline_unfilter_unit.sv =====
// Top level of the PNG scanline unfilter unit: filter type decode and byte reconstruction.
//
// Channel  Dir  tdata           tuser          tlast
// s_axis   in   byte_in[7:0]    image_start    -
// m_axis   out  pixel[7:0]      bad_filter     row_end
// cfg      in   index 0 bytes_per_pixel, index 1 row_bytes
//
// One request is taken per cycle unless a stalled result holds a pixel request; each
// passes the input register, then the result register. The previous scanline sits
// in a 4096-byte memory that is read one column ahead, with a bypass when the column just
// written is read again. Reset clears all control state; no clearing pass is needed.
// A stalled result holds the pipeline only for pixel requests behind it.
`timescale 1ns / 1ps
`default_nettype none
module png_scanline_unfilter_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [pngsu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pngsu_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [7:0]                       s_axis_tdata,   // [7:0] byte_in
	input  wire logic                             s_axis_tuser,   // [0] image_start
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	output logic [7:0]                            m_axis_tdata,   // [7:0] pixel
	output logic                                  m_axis_tuser,   // [0] bad_filter
	output logic                                  m_axis_tlast
);
	import pngsu_pkg::*;

	logic [BPP_W-1:0]   bpp_q;
	logic [ROW_W-1:0]   row_q;

	logic               vld_s1;
	logic [7:0]         byte_s1;
	logic               start_s1;

	logic [ADDR_W-1:0]  col_q;
	filter_t            filt_q;
	logic               first_q;
	logic               await_q;
	logic               bad_q;
	logic [7:0]         left_q [MAX_BYTES_PER_PIXEL];
	logic [7:0]         ul_q [MAX_BYTES_PER_PIXEL];

	logic [7:0]         above_mem [MAX_ROW_BYTES];
	logic [7:0]         rd_q;
	logic               byp_q;
	logic [7:0]         byp_data_q;

	logic               out_vld_q;
	logic [7:0]         out_pix_q;
	logic               out_last_q;
	logic               out_bad_q;

	logic               eff_first;
	logic               eff_await;
	logic               out_free;
	logic               proc;
	logic               pix_go;
	logic [BPP_W-1:0]   bpp_eff;
	logic [ROW_W-1:0]   len_eff;
	logic [HIST_IDX_W-1:0] hidx;
	logic               has_left;
	logic [7:0]         a;
	logic [7:0]         b;
	logic [7:0]         c;
	logic [8:0]         ab_sum;
	logic [7:0]         pred;
	logic [7:0]         recon;
	logic               last;
	logic [ADDR_W-1:0]  col_d;
	logic               type_bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q <= BPP_RESET;
			row_q <= ROW_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_BYTES_PER_PIXEL: bpp_q <= cfg_data[BPP_W-1:0];
				REG_ROW_BYTES:       row_q <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (bpp_q == '0) begin
			bpp_eff = BPP_W'(1);
		end else if (bpp_q > BPP_W'(MAX_BYTES_PER_PIXEL)) begin
			bpp_eff = BPP_W'(MAX_BYTES_PER_PIXEL);
		end else begin
			bpp_eff = bpp_q;
		end
		if (row_q == '0) begin
			len_eff = ROW_W'(1);
		end else if (row_q > ROW_W'(MAX_ROW_BYTES)) begin
			len_eff = ROW_W'(MAX_ROW_BYTES);
		end else begin
			len_eff = row_q;
		end
	end

	assign eff_first = start_s1 | first_q;
	assign eff_await = start_s1 | await_q;
	assign out_free  = !out_vld_q || m_axis_tready;
	assign proc      = vld_s1 && (eff_await || out_free);
	assign pix_go    = proc && !eff_await;
	assign s_axis_tready = !vld_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	always_comb begin
		hidx     = HIST_IDX_W'(bpp_eff - BPP_W'(1));
		has_left = ({{(ROW_W-ADDR_W){1'b0}}, col_q} >= ROW_W'(bpp_eff));
		a        = has_left ? left_q[hidx] : 8'd0;
		b        = eff_first ? 8'd0 : (byp_q ? byp_data_q : rd_q);
		c        = (has_left && !eff_first) ? ul_q[hidx] : 8'd0;
		ab_sum   = {1'b0, a} + {1'b0, b};
		case (filt_q)
			FILT_NONE:  pred = 8'd0;
			FILT_SUB:   pred = a;
			FILT_UP:    pred = b;
			FILT_AVG:   pred = ab_sum[8:1];
			FILT_PAETH: pred = paeth_pred(a, b, c);
			default:    pred = 8'd0;
		endcase
		recon    = byte_s1 + pred;
		last     = ({{(ROW_W-ADDR_W){1'b0}}, col_q} + ROW_W'(1)) >= len_eff;
		type_bad = byte_s1 > FILT_MAX_CODE;
		if (!proc) begin
			col_d = col_q;
		end else if (eff_await || last) begin
			col_d = '0;
		end else begin
			col_d = col_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			filt_q  <= FILT_NONE;
			first_q <= 1'b1;
			await_q <= 1'b1;
			bad_q   <= 1'b0;
			for (int i = 0; i < MAX_BYTES_PER_PIXEL; i++) begin
				left_q[i] <= 8'd0;
				ul_q[i]   <= 8'd0;
			end
		end else if (proc) begin
			col_q <= col_d;
			if (eff_await) begin
				first_q <= eff_first;
				await_q <= 1'b0;
				bad_q   <= type_bad;
				filt_q  <= type_bad ? FILT_NONE : filter_t'(byte_s1[2:0]);
			end else begin
				first_q <= eff_first && !last;
				await_q <= last;
				left_q[0] <= recon;
				ul_q[0]   <= b;
				for (int i = 1; i < MAX_BYTES_PER_PIXEL; i++) begin
					left_q[i] <= left_q[i-1];
					ul_q[i]   <= ul_q[i-1];
				end
			end
		end
	end

	// The memory is read at the column of the next request.
	always_ff @(posedge clk) begin
		if (pix_go) begin
			above_mem[col_q] <= recon;
		end
		rd_q       <= above_mem[col_d];
		byp_data_q <= recon;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= pix_go && (col_d == col_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (pix_go) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_go) begin
			out_pix_q  <= recon;
			out_last_q <= last;
			out_bad_q  <= bad_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_pix_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_bad_q;

endmodule
`default_nettype wire

// ===== sv/pngsu_checker.sv =====
// Port checker of the scanline unfilter unit and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "png_scanline_unfilter_unit_assert.svh"
module pngsu_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tvalid,
	input wire logic       s_axis_tready,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata,
	input wire logic       m_axis_tuser,
	input wire logic       m_axis_tlast
);

	// A stalled result keeps its value.
	`PNGSU_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

	// With no result pending the unit always takes a request.
	`PNGSU_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !m_axis_tvalid, s_axis_tready, "input stalled while output is empty")

	// A result appearing on an empty output comes from a request that passed the input register.
	`PNGSU_ASSERT_NOW(a_result_source, clk, arst_n, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2), "result without a matching request")

endmodule

bind png_scanline_unfilter_unit pngsu_checker u_pngsu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// ===== sim/tb_png_scanline_unfilter_unit.sv =====
// Self-checking testbench of the PNG scanline unfilter unit with a byte-level predictor.
`timescale 1ns / 1ps
module tb_png_scanline_unfilter_unit;
	import pngsu_pkg::*;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int HOLD_CYCLES  = 120;
	localparam int DRAIN_SLACK  = 8;

	typedef struct packed {
		logic [7:0] pixel;
		logic       row_end;
		logic       bad_filter;
	} pix_t;

	typedef enum logic {STEP_BYTE, STEP_REG} step_kind_t;

	typedef struct packed {
		step_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
		logic                   start;
		logic [7:0]             data;
		logic                   typed;
		logic [7:0]             px;
		logic                   row_end;
		logic                   bad;
	} dir_step_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [7:0]            m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;

	png_scanline_unfilter_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #2 clk = ~clk;

	pix_t            expected_pixels [$];
	logic [7:0]      prior_row [MAX_ROW_BYTES];
	bit              prior_row_valid [MAX_ROW_BYTES];
	logic [7:0]      recon_hist [MAX_BYTES_PER_PIXEL];
	logic [7:0]      above_hist [MAX_BYTES_PER_PIXEL];
	logic [ROW_W-1:0] col_q = '0;
	filter_t         filt_q = FILT_NONE;
	bit              first_row_q = 1'b1;
	bit              await_type_q = 1'b1;
	bit              row_bad_q = 1'b0;
	logic [BPP_W-1:0] bpp_q = BPP_RESET;
	logic [ROW_W-1:0] row_len_q = ROW_RESET;

	int mismatches = 0;
	int requests_sent = 0;
	int pixels_checked = 0;
	int reg_writes = 0;
	int cycles = 0;
	int rx_mode = 1;
	int gap_max = 3;
	int burst_left = 1;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;
	int rx_tick = 0;

	dir_step_t directed_steps [0:26] = '{
		'{STEP_BYTE, '0, '0, 1'b1, 8'(FILT_NONE), 1'b0, 8'h00, 1'b0, 1'b0},
		'{STEP_BYTE, '0, '0, 1'b0, 8'hFF, 1'b1, 8'hFF, 1'b0, 1'b0},
		'{STEP_BYTE, '0, '0, 1'b0, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0},
		'{STEP_BYTE, '0, '0, 1'b1, 8'h07, 1'b0, 8'h00, 1'b0, 1'b0},
		'{STEP_BYTE, '0, '0, 1'b0, 8'h80, 1'b1, 8'h80, 1'b0, 1'b1},
		'{STEP_REG, REG_BYTES_PER_PIXEL, 13'd1, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
		'{STEP_REG, REG_ROW_BYTES, 13'd2, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
		'{STEP_BYTE, '0, '0, 1'b1, 8'(FILT_SUB), 1'b0, 8'h00, 1'b0, 1'b0},
		'{STEP_BYTE, '0, '0, 1'b0, 8'h10, 1'b1, 8'h10, 1'b0, 1'b0},
		'{STEP_BYTE, '0, '0, 1'b0, 8'hF0, 1'b1, 8'h00, 1'b1, 1'b0},
		'{STEP_BYTE, '0, '0, 1'b0, 8'(FILT_UP), 1'b0, 8'h00, 1'b0, 1'b0},
		'{STEP_BYTE, '0, '0, 1'b0, 8'h01, 1'b0, 8'h00, 1'b0, 1'b0},
		'{STEP_BYTE, '0, '0, 1'b0, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0},
		'{STEP_BYTE, '0, '0, 1'b0, 8'(FILT_AVG), 1'b0, 8'h00, 1'b0, 1'b0},
		'{STEP_BYTE, '0, '0, 1'b0, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0},
		'{STEP_BYTE, '0, '0, 1'b0, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0},
		'{STEP_BYTE, '0, '0, 1'b0, 8'(FILT_PAETH), 1'b0, 8'h00, 1'b0, 1'b0},
		'{STEP_BYTE, '0, '0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
		'{STEP_BYTE, '0, '0, 1'b0, 8'h7F, 1'b0, 8'h00, 1'b0, 1'b0},
		'{STEP_BYTE, '0, '0, 1'b0, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0},
		'{STEP_BYTE, '0, '0, 1'b0, 8'h00, 1'b1, 8'h00, 1'b0, 1'b1},
		'{STEP_BYTE, '0, '0, 1'b0, 8'h01, 1'b1, 8'h01, 1'b1, 1'b1},
		'{STEP_BYTE, '0, '0, 1'b0, FILT_MAX_CODE + 8'd1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{STEP_BYTE, '0, '0, 1'b0, 8'h00, 1'b1, 8'h00, 1'b0, 1'b1},
		'{STEP_BYTE, '0, '0, 1'b0, 8'hAA, 1'b1, 8'hAA, 1'b1, 1'b1},
		'{STEP_BYTE, '0, '0, 1'b1, 8'(FILT_PAETH), 1'b0, 8'h00, 1'b0, 1'b0},
		'{STEP_BYTE, '0, '0, 1'b0, 8'h3C, 1'b0, 8'h00, 1'b0, 1'b0}
	};

	function automatic void unfilter_byte(input logic [7:0] x, input logic st,
		output bit produced, output pix_t res);
		int span;
		int len;
		int ai;
		int bi;
		int ci;
		int p;
		int pa;
		int pb;
		int pc;
		logic [7:0] pred;
		produced = 1'b0;
		res = '0;
		if (st) begin
			first_row_q = 1'b1;
			await_type_q = 1'b1;
			col_q = '0;
		end
		if (await_type_q) begin
			row_bad_q = x > FILT_MAX_CODE;
			filt_q = row_bad_q ? FILT_NONE : filter_t'(x[2:0]);
			await_type_q = 1'b0;
			col_q = '0;
			return;
		end
		span = (bpp_q == 0) ? 1 : (bpp_q > MAX_BYTES_PER_PIXEL ? MAX_BYTES_PER_PIXEL : bpp_q);
		len = (row_len_q == 0) ? 1 : (row_len_q > MAX_ROW_BYTES ? MAX_ROW_BYTES : row_len_q);
		if (col_q >= MAX_ROW_BYTES)
			col_q = ROW_W'(MAX_ROW_BYTES - 1);
		ai = (col_q >= span) ? int'(recon_hist[span-1]) : 0;
		bi = first_row_q ? 0 : int'(prior_row[col_q]);
		ci = (col_q >= span && !first_row_q) ? int'(above_hist[span-1]) : 0;
		case (filt_q)
			FILT_SUB: pred = 8'(ai);
			FILT_UP: pred = 8'(bi);
			FILT_AVG: pred = 8'((ai + bi) >> 1);
			FILT_PAETH: begin
				p = ai + bi - ci;
				pa = p > ai ? p - ai : ai - p;
				pb = p > bi ? p - bi : bi - p;
				pc = p > ci ? p - ci : ci - p;
				if (pa <= pb && pa <= pc)
					pred = 8'(ai);
				else if (pb <= pc)
					pred = 8'(bi);
				else
					pred = 8'(ci);
			end
			default: pred = 8'h00;
		endcase
		res.pixel = x + pred;
		prior_row[col_q] = res.pixel;
		prior_row_valid[col_q] = 1'b1;
		for (int k = MAX_BYTES_PER_PIXEL - 1; k > 0; k--) begin
			recon_hist[k] = recon_hist[k-1];
			above_hist[k] = above_hist[k-1];
		end
		recon_hist[0] = res.pixel;
		above_hist[0] = 8'(bi);
		res.row_end = (int'(col_q) + 1 >= len);
		res.bad_filter = row_bad_q;
		if (res.row_end) begin
			col_q = '0;
			await_type_q = 1'b1;
			first_row_q = 1'b0;
		end else begin
			col_q = col_q + 1'b1;
		end
		produced = 1'b1;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic st, input bit typed = 1'b0,
		input pix_t typed_pix = '0);
		bit produced;
		pix_t res;
		int gap;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= st;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		requests_sent++;
		unfilter_byte(b, st, produced, res);
		if (produced)
			expected_pixels.push_back(typed ? typed_pix : res);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		settle();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_BYTES_PER_PIXEL)
			bpp_q = val[BPP_W-1:0];
		else
			row_len_q = val[ROW_W-1:0];
		reg_writes++;
	endtask

	task automatic stream_rows(input int n);
		logic st;
		logic [7:0] b;
		int c;
		for (int i = 0; i < n; i++) begin
			c = (col_q >= MAX_ROW_BYTES) ? MAX_ROW_BYTES - 1 : int'(col_q);
			st = await_type_q ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 49) == 0);
			if (!st && !await_type_q && !first_row_q && !prior_row_valid[c])
				st = 1'b1;
			if (st || await_type_q)
				b = ($urandom_range(0, 5) == 0) ? 8'($urandom) :
					8'($urandom_range(FILT_NONE, FILT_PAETH));
			else
				case ($urandom_range(0, 9))
					0: b = 8'h00;
					1: b = 8'hFF;
					default: b = 8'($urandom);
				endcase
			send_byte(b, st);
		end
	endtask

	task automatic flag_miss(input string what, input int want, input int got);
		if (mismatches < 10)
			$display("Mismatch in %s at %0t ns: expected %0h, got %0h", what, $time, want, got);
		mismatches++;
	endtask

	always @(negedge clk) begin
		if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_ack != hold_req) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			rx_tick <= rx_tick + 1;
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= (rx_tick % 7) >= 2;
				default: m_axis_tready <= $urandom_range(0, 9) != 0;
			endcase
		end
	end

	always @(posedge clk) begin
		pix_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			pixels_checked++;
			if (expected_pixels.size() == 0) begin
				flag_miss("pixel with nothing pending", 0, m_axis_tdata);
			end else begin
				want = expected_pixels.pop_front();
				if (m_axis_tdata !== want.pixel)
					flag_miss("pixel", want.pixel, m_axis_tdata);
				if (m_axis_tlast !== want.row_end)
					flag_miss("row_end", want.row_end, m_axis_tlast);
				if (m_axis_tuser !== want.bad_filter)
					flag_miss("bad_filter", want.bad_filter, m_axis_tuser);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles with %0d pixels pending", cycles,
				expected_pixels.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int bpp_picks [8] = '{0, 1, 8, 15, 2, 3, 5, 7};
		int row_picks [8] = '{0, 1, 2, 3, 5, 8, 13, 30};
		int cfg_sel;
		logic [CFG_DATA_W-1:0] d;
		cfg_sel = 0;
		foreach (prior_row[i]) begin
			prior_row[i] = 8'h00;
			prior_row_valid[i] = 1'b0;
		end
		foreach (recon_hist[i]) begin
			recon_hist[i] = 8'h00;
			above_hist[i] = 8'h00;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_steps[i]) begin
			if (directed_steps[i].kind == STEP_REG)
				write_reg(directed_steps[i].idx, directed_steps[i].val);
			else
				send_byte(directed_steps[i].data, directed_steps[i].start, directed_steps[i].typed,
					{directed_steps[i].px, directed_steps[i].row_end, directed_steps[i].bad});
		end

		for (int ph = 0; ph < 12; ph++) begin
			if (ph % 3 != 2) begin
				d = CFG_DATA_W'($urandom);
				d[BPP_W-1:0] = BPP_W'(bpp_picks[cfg_sel]);
				write_reg(REG_BYTES_PER_PIXEL, d);
				write_reg(REG_ROW_BYTES, CFG_DATA_W'(row_picks[cfg_sel]));
				cfg_sel++;
			end else begin
				settle();
			end
			rx_mode = $urandom_range(0, 3);
			gap_max = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
			if (ph == 3) begin
				gap_max = 0;
				hold_req++;
			end
			stream_rows(30);
			if (ph == 5) begin
				write_reg(REG_ROW_BYTES, {CFG_DATA_W{1'b1}});
				write_reg(REG_BYTES_PER_PIXEL, CFG_DATA_W'(15));
				gap_max = 0;
				rx_mode = 0;
				send_byte(8'(FILT_NONE), 1'b1);
				repeat (24) send_byte(8'($urandom), 1'b0);
				send_byte(8'(FILT_PAETH), 1'b1);
				repeat (24) send_byte(8'($urandom), 1'b0);
			end
		end

		settle();
		repeat (DRAIN_SLACK) @(posedge clk);
		$display("Sent %0d requests and checked %0d pixels over %0d register writes.",
			requests_sent, pixels_checked, reg_writes);
		$display("All five filters, bad types, image restarts, clamped settings and a long stall were run.");
		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches, %0d pixels never seen", mismatches, expected_pixels.size());
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
